@@ src/crd_pkg.sv @@
// Package for the clipping run detector: widths, register codes, reset values and shared types.
`default_nettype none
package crd_pkg;

    // Fixed field widths.
    localparam int SAMPLE_BITS = 24;
    localparam int INDEX_BITS  = 32;
    localparam int COUNT_BITS  = 32;
    localparam int LEN_BITS    = 16;
    localparam int LEVEL_BITS  = 24;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 4;

    // Full-scale magnitude of a sample.
    localparam int unsigned SAMPLE_FULL_SCALE = 2 ** (SAMPLE_BITS - 1);

    // Register reset values.
    localparam logic [LEN_BITS-1:0]   MIN_RUN_RESET    = LEN_BITS'(3);
    localparam logic [LEN_BITS-1:0]   STOP_LEN_RESET   = LEN_BITS'(3);
    localparam logic [LEVEL_BITS-1:0] CLIP_LEVEL_RESET = LEVEL_BITS'(SAMPLE_FULL_SCALE - 1);
    localparam logic [INDEX_BITS-1:0] BASE_INDEX_RESET = '0;

    // Saturation limit of the counters.
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Register index codes, taken from paddr word address.
    typedef enum logic [1:0] {
        REG_MIN_RUN,
        REG_STOP_LEN,
        REG_CLIP_LEVEL,
        REG_BASE_INDEX
    } t_reg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [LEN_BITS-1:0]   min_run;
        logic [LEN_BITS-1:0]   stop_len;
        logic [LEVEL_BITS-1:0] clip_level;
        logic [INDEX_BITS-1:0] base_index;
    } t_cfg;

    // Classified item held in the input register.
    typedef struct packed {
        logic clipped;
        logic last;
    } t_item;

    // One run label.
    typedef struct packed {
        logic [INDEX_BITS-1:0] run_start;
        logic [INDEX_BITS-1:0] run_end;
        logic [COUNT_BITS-1:0] clipped_count;
        logic [COUNT_BITS-1:0] span_count;
    } t_result;

endpackage
`default_nettype wire

@@ src/crd_in_if.sv @@
// Input channel interface: one audio sample item per handshake.
`default_nettype none
interface crd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [crd_pkg::SAMPLE_BITS-1:0]  sample;
    logic                                    last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface
`default_nettype wire

@@ src/crd_out_if.sv @@
// Output channel interface: one run label item per handshake.
`default_nettype none
interface crd_out_if;
    logic                             valid;
    logic                             ready;
    logic [crd_pkg::INDEX_BITS-1:0]   run_start;
    logic [crd_pkg::INDEX_BITS-1:0]   run_end;
    logic [crd_pkg::COUNT_BITS-1:0]   clipped_count;
    logic [crd_pkg::COUNT_BITS-1:0]   span_count;

    modport source (output valid, output run_start, output run_end,
                    output clipped_count, output span_count, input ready);
    modport sink   (input valid, input run_start, input run_end,
                    input clipped_count, input span_count, output ready);
endinterface
`default_nettype wire

@@ src/crd_cfg.sv @@
// APB-style configuration registers of the clipping run detector.
`default_nettype none
module crd_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [crd_pkg::ADDR_BITS-1:0] i_paddr,
    input  wire logic [crd_pkg::DATA_BITS-1:0] i_pwdata,
    output logic      [crd_pkg::DATA_BITS-1:0] o_prdata,
    output logic                               o_pready,
    output crd_pkg::t_cfg                      o_cfg
);

    crd_pkg::t_cfg    r_cfg;
    crd_pkg::t_cfg    n_cfg;
    crd_pkg::t_reg_idx w_idx;
    logic             w_write;

    assign w_idx    = crd_pkg::t_reg_idx'(i_paddr[3:2]);
    assign w_write  = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // Register write decode.
    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (w_idx)
                crd_pkg::REG_MIN_RUN:    n_cfg.min_run    = i_pwdata[crd_pkg::LEN_BITS-1:0];
                crd_pkg::REG_STOP_LEN:   n_cfg.stop_len   = i_pwdata[crd_pkg::LEN_BITS-1:0];
                crd_pkg::REG_CLIP_LEVEL: n_cfg.clip_level = i_pwdata[crd_pkg::LEVEL_BITS-1:0];
                crd_pkg::REG_BASE_INDEX: n_cfg.base_index = i_pwdata[crd_pkg::INDEX_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_run    <= crd_pkg::MIN_RUN_RESET;
            r_cfg.stop_len   <= crd_pkg::STOP_LEN_RESET;
            r_cfg.clip_level <= crd_pkg::CLIP_LEVEL_RESET;
            r_cfg.base_index <= crd_pkg::BASE_INDEX_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Register read mux.
    always_comb begin
        unique case (w_idx)
            crd_pkg::REG_MIN_RUN:    o_prdata = crd_pkg::DATA_BITS'(r_cfg.min_run);
            crd_pkg::REG_STOP_LEN:   o_prdata = crd_pkg::DATA_BITS'(r_cfg.stop_len);
            crd_pkg::REG_CLIP_LEVEL: o_prdata = crd_pkg::DATA_BITS'(r_cfg.clip_level);
            crd_pkg::REG_BASE_INDEX: o_prdata = crd_pkg::DATA_BITS'(r_cfg.base_index);
            default:                 o_prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/crd_in_stage.sv @@
// Input register: takes a sample item and holds its clip decision and channel-end flag.
`default_nettype none
module crd_in_stage (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    crd_in_if.sink                              i_in,
    input  wire logic [crd_pkg::LEVEL_BITS-1:0] i_clip_level,
    input  wire logic                           i_pop,
    output logic                                o_valid,
    output crd_pkg::t_item                      o_item
);

    logic                             r_valid;
    crd_pkg::t_item                   r_item;
    logic [crd_pkg::SAMPLE_BITS-1:0]  w_mag;
    logic                             w_take;

    // The register is free when empty or when the core drains it this cycle.
    assign i_in.ready = !r_valid || i_pop;
    assign w_take     = i_in.valid && i_in.ready;

    // Magnitude of a two's complement sample; the most negative value maps to full scale.
    assign w_mag = i_in.sample[crd_pkg::SAMPLE_BITS-1] ? (~i_in.sample + 1'b1) : i_in.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.clipped <= (crd_pkg::LEVEL_BITS'(w_mag) >= i_clip_level);
            r_item.last    <= i_in.last_sample;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

@@ src/crd_core.sv @@
// Run tracking state and the per-sample update that forms a label.
`default_nettype none
module crd_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire crd_pkg::t_cfg  i_cfg,
    input  wire logic    i_valid,
    input  wire crd_pkg::t_item i_item,
    input  wire logic    i_out_free,
    output logic         o_pop,
    output logic         o_push,
    output crd_pkg::t_result o_result
);

    logic [crd_pkg::COUNT_BITS-1:0] r_sample_position, n_sample_position;
    logic [crd_pkg::COUNT_BITS-1:0] r_clip_run, n_clip_run;
    logic [crd_pkg::LEN_BITS-1:0]   r_quiet_run, n_quiet_run;
    logic [crd_pkg::COUNT_BITS-1:0] r_span_run, n_span_run;
    logic [crd_pkg::INDEX_BITS-1:0] r_first_clip_index, n_first_clip_index;

    logic [crd_pkg::INDEX_BITS-1:0] w_abs_index;
    logic [crd_pkg::COUNT_BITS-1:0] w_clip_inc;
    logic [crd_pkg::COUNT_BITS-1:0] w_span_inc;
    logic [crd_pkg::COUNT_BITS-1:0] w_pos_inc;
    logic [crd_pkg::LEN_BITS-1:0]   w_quiet_inc;
    logic [crd_pkg::COUNT_BITS-1:0] w_stop_wide;
    logic                           w_qualified;
    logic                           w_emit;

    // Shared arithmetic on the current state.
    assign w_abs_index = i_cfg.base_index + crd_pkg::INDEX_BITS'(r_sample_position);
    assign w_clip_inc  = (r_clip_run == crd_pkg::COUNT_MAX) ? r_clip_run : r_clip_run + 1'b1;
    assign w_span_inc  = (r_span_run == crd_pkg::COUNT_MAX) ? r_span_run : r_span_run + 1'b1;
    assign w_pos_inc   = (r_sample_position == crd_pkg::COUNT_MAX) ?
                         r_sample_position : r_sample_position + 1'b1;
    assign w_quiet_inc = r_quiet_run + 1'b1;
    assign w_stop_wide = crd_pkg::COUNT_BITS'(i_cfg.stop_len);
    assign w_qualified = (r_clip_run != '0) &&
                         (r_clip_run >= crd_pkg::COUNT_BITS'(i_cfg.min_run));

    // A qualified run closes on the unclipped sample that completes the quiet count.
    assign w_emit = !i_item.clipped && w_qualified && (w_quiet_inc >= i_cfg.stop_len);

    // Items that make no label pass even while the output register is full.
    assign o_pop  = i_valid && (!w_emit || i_out_free);
    assign o_push = o_pop && w_emit;

    // Label fields.
    always_comb begin
        o_result.run_start     = r_first_clip_index;
        o_result.run_end       = w_abs_index - crd_pkg::INDEX_BITS'(i_cfg.stop_len);
        o_result.clipped_count = r_clip_run;
        o_result.span_count    = (w_span_inc >= w_stop_wide) ? (w_span_inc - w_stop_wide) : '0;
    end

    // Next state of the run counters.
    always_comb begin
        n_sample_position  = r_sample_position;
        n_clip_run         = r_clip_run;
        n_quiet_run        = r_quiet_run;
        n_span_run         = r_span_run;
        n_first_clip_index = r_first_clip_index;
        if (o_pop) begin
            if (i_item.clipped) begin
                // A clipped sample opens a run or clears the quiet count of an open one.
                if (r_clip_run == '0) begin
                    n_first_clip_index = w_abs_index;
                    n_span_run         = crd_pkg::COUNT_BITS'(1);
                end else begin
                    n_quiet_run = '0;
                    n_span_run  = w_span_inc;
                end
                n_clip_run = w_clip_inc;
            end else if (w_qualified) begin
                n_quiet_run = w_quiet_inc;
                n_span_run  = w_span_inc;
                if (w_emit) begin
                    n_clip_run  = '0;
                    n_quiet_run = '0;
                    n_span_run  = '0;
                end
            end else begin
                // A short run is dropped at its first unclipped sample.
                n_clip_run  = '0;
                n_quiet_run = '0;
            end
            n_sample_position = w_pos_inc;
            // Channel end clears everything, dropping any open run.
            if (i_item.last) begin
                n_sample_position  = '0;
                n_clip_run         = '0;
                n_quiet_run        = '0;
                n_span_run         = '0;
                n_first_clip_index = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_position  <= '0;
            r_clip_run         <= '0;
            r_quiet_run        <= '0;
            r_span_run         <= '0;
            r_first_clip_index <= '0;
        end else begin
            r_sample_position  <= n_sample_position;
            r_clip_run         <= n_clip_run;
            r_quiet_run        <= n_quiet_run;
            r_span_run         <= n_span_run;
            r_first_clip_index <= n_first_clip_index;
        end
    end

    // The quiet count only exists inside an open run.
    a_quiet_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clip_run == '0) |-> (r_quiet_run == '0))
        else $error("quiet count set with no open run");

    // A label comes only from an unclipped sample closing an open run.
    a_push_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_clip_run != '0) && !i_item.clipped && i_out_free)
        else $error("label pushed without a closing sample or output space");

    // The end of a channel leaves all run state cleared.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_sample_position == '0) && (r_clip_run == '0) &&
                                   (r_span_run == '0))
        else $error("state not cleared after channel end");

    // Within a channel the position always moves past zero.
    a_position_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.last) |=> (r_sample_position != '0))
        else $error("sample position did not advance");

endmodule
`default_nettype wire

@@ src/crd_out_reg.sv @@
// Output register: holds one run label until the receiver takes it.
`default_nettype none
module crd_out_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire crd_pkg::t_result i_result,
    output logic            o_free,
    crd_out_if.source       o_out
);

    logic             r_valid;
    crd_pkg::t_result r_result;

    // Free when empty or when the held label leaves this cycle.
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.run_start     = r_result.run_start;
    assign o_out.run_end       = r_result.run_end;
    assign o_out.clipped_count = r_result.clipped_count;
    assign o_out.span_count    = r_result.span_count;

endmodule
`default_nettype wire

@@ src/clipping_run_detector_top.sv @@
// Top level of the clipping run detector.
//
// Samples enter on i_in (valid/ready, signed sample plus last_sample flag).
// Run labels leave on o_out (valid/ready, run_start, run_end, clipped_count,
// span_count). Zero or one label is produced per sample.
// Registers min_run, stop_len, clip_level and base_index sit on an APB-style
// port at byte addresses 0, 4, 8 and 12; pready is always high. Write them
// only while no item is in flight.
// Throughput is one sample per cycle while no closing sample waits for the
// output register: the run counters update from the input register with
// no stage between, so the state loop closes every cycle. A label is formed
// from its sample in the input register and held in the output register.
// When the receiver stalls, samples that close no run keep flowing; the
// sample that closes a run waits in the input register until the held label
// is taken, and i_in.ready drops behind it.
// Reset clears the run state, empties both registers and restores the
// register defaults; no clearing pass follows, items are taken at once.
`default_nettype none
module clipping_run_detector_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    crd_in_if.sink                             i_in,
    crd_out_if.source                          o_out,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [crd_pkg::ADDR_BITS-1:0] i_paddr,
    input  wire logic [crd_pkg::DATA_BITS-1:0] i_pwdata,
    output logic      [crd_pkg::DATA_BITS-1:0] o_prdata,
    output logic                               o_pready
);

    crd_pkg::t_cfg    w_cfg;
    crd_pkg::t_item   w_item;
    crd_pkg::t_result w_result;
    logic             w_item_valid;
    logic             w_pop;
    logic             w_push;
    logic             w_out_free;

    // Configuration registers.
    crd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // Input register with clip decision.
    crd_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_clip_level (w_cfg.clip_level),
        .i_pop        (w_pop),
        .o_valid      (w_item_valid),
        .o_item       (w_item)
    );

    // Run state and label forming.
    crd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_item_valid),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .o_pop      (w_pop),
        .o_push     (w_push),
        .o_result   (w_result)
    );

    // Output register.
    crd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire
